### design/dasc_pkg.sv
// ----------------------------------------------------------------------------
// dasc_pkg
// Shared constants, word types and register codes of the deep alpha
// sub-step counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dasc_pkg;

	// fixed-point format of alpha and width of the tile total
	localparam int ALPHA_FRAC_BITS = 16;
	localparam int TOTAL_WIDTH     = 32;

	// derived widths
	localparam int SAMPLE_W    = ALPHA_FRAC_BITS + 1;
	localparam int PROD_W      = 2 * ALPHA_FRAC_BITS + 1;
	localparam int STEPS_W     = 14;
	localparam int OUT_TOTAL_W = 32;
	localparam int DIV_CNT_W   = $clog2(SAMPLE_W + 1);

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// alpha constants
	localparam logic [SAMPLE_W-1:0] ONE_ALPHA = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};
	localparam int MIN_THRESH_INT = ((1 << ALPHA_FRAC_BITS) + 9999) / 10000;
	localparam logic [SAMPLE_W-1:0] MIN_THRESH = SAMPLE_W'(MIN_THRESH_INT);

	// saturation limits
	localparam logic [STEPS_W-1:0]     SUB_MAX   = {STEPS_W{1'b1}};
	localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = {TOTAL_WIDTH{1'b1}};

	// register reset values
	localparam logic [SAMPLE_W-1:0] MAX_SUB_ALPHA_RST = SAMPLE_W'(6554);

	// register indexes
	typedef enum logic [0:0] {
		REG_MAX_SUB_ALPHA,
		REG_ALPHA_PRESENT
	} reg_idx_t;

	// input word
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_alpha;
		logic                pixel_end;
		logic                tile_start;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [STEPS_W-1:0]     sub_steps;
		logic [OUT_TOTAL_W-1:0] running_total;
		logic                   offset_valid;
	} out_word_t;

	// configuration register contents
	typedef struct packed {
		logic [SAMPLE_W-1:0] max_sub_alpha;
		logic                alpha_present;
	} cfg_t;

	// divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
		logic rem_nz;
	} div_stat_t;

endpackage

`default_nettype wire

### design/dasc_apb_regs.sv
// ----------------------------------------------------------------------------
// dasc_apb_regs
// APB-style register file holding the sub-sample alpha limit and the
// alpha-present flag.
// ----------------------------------------------------------------------------
`default_nettype none

module dasc_apb_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [dasc_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [dasc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [dasc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                pready,
	output dasc_pkg::cfg_t                      cfg
);

	dasc_pkg::reg_idx_t reg_idx;
	logic               wr_en;
	dasc_pkg::cfg_t     cfg_q;

	// decode the register from the word address
	assign reg_idx = dasc_pkg::reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// hold the registers, write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_sub_alpha <= dasc_pkg::MAX_SUB_ALPHA_RST;
			cfg_q.alpha_present <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				dasc_pkg::REG_MAX_SUB_ALPHA: begin
					cfg_q.max_sub_alpha <= pwdata[dasc_pkg::SAMPLE_W-1:0];
				end
				dasc_pkg::REG_ALPHA_PRESENT: begin
					cfg_q.alpha_present <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		case (reg_idx)
			dasc_pkg::REG_MAX_SUB_ALPHA: begin
				prdata = dasc_pkg::CFG_DATA_W'(cfg_q.max_sub_alpha);
			end
			dasc_pkg::REG_ALPHA_PRESENT: begin
				prdata = dasc_pkg::CFG_DATA_W'(cfg_q.alpha_present);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

### design/dasc_div.sv
// ----------------------------------------------------------------------------
// dasc_div
// Restoring divider, one quotient bit per cycle. Gives the quotient and
// whether the remainder is non-zero, for a ceiling division.
// ----------------------------------------------------------------------------
`default_nettype none

module dasc_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [dasc_pkg::SAMPLE_W-1:0] dividend,
	input  wire logic [dasc_pkg::SAMPLE_W-1:0] divisor,
	output logic      [dasc_pkg::SAMPLE_W-1:0] quotient,
	output dasc_pkg::div_stat_t                stat
);

	logic                           busy_q;
	logic                           done_q;
	logic [dasc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [dasc_pkg::SAMPLE_W-1:0]  rem_q;
	logic [dasc_pkg::SAMPLE_W-1:0]  quo_q;
	logic [dasc_pkg::SAMPLE_W-1:0]  divisor_q;
	logic [dasc_pkg::SAMPLE_W:0]    trial;
	logic                           ge;
	logic [dasc_pkg::SAMPLE_W-1:0]  rem_next;

	// shift in the next dividend bit and try the subtraction
	assign trial    = {rem_q, quo_q[dasc_pkg::SAMPLE_W-1]};
	assign ge       = trial >= {1'b0, divisor_q};
	assign rem_next = ge ? dasc_pkg::SAMPLE_W'(trial - {1'b0, divisor_q})
	                     : trial[dasc_pkg::SAMPLE_W-1:0];

	assign quotient    = quo_q;
	assign stat.busy   = busy_q;
	assign stat.done   = done_q;
	assign stat.rem_nz = |rem_q;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= dasc_pkg::DIV_CNT_W'(dasc_pkg::SAMPLE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == dasc_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[dasc_pkg::SAMPLE_W-2:0], ge};
		end
	end

	// a finished division is never still iterating
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while busy");

endmodule

`default_nettype wire

### design/deep_alpha_substep_counter.sv
// ----------------------------------------------------------------------------
// deep_alpha_substep_counter
// Splits deep-image samples into sub-samples from their over-composited alpha
// and keeps a saturating per-tile running total of sub-samples.
//
// Input channel (in_valid/in_ready/in_data) carries one sample word: alpha in
// unsigned Q1.16, a pixel-end flag and a tile-start flag. The output channel
// (out_valid/out_ready/out_data) returns one word per sample: its sub-step
// count, the running total including it, and a flag marking the total as a
// pixel's output sample offset.
// Each word runs from acceptance to the next acceptance through these steps,
// with a free output: the product, its rounding, one quotient bit per cycle
// in the restoring divider, seeing the divider finish, the update and the
// return to idle. The next sample is not taken before that return.
// A finished word waits in the output register; the next sample is taken while
// it waits, and only the update at the end of that sample waits for the slot.
// Reset clears the accumulated alpha and the total and restores the registers
// (limit 6554, alpha present).
// Registers: 0 max_sub_alpha at 0x0, 1 alpha_present at 0x4.
// ----------------------------------------------------------------------------
`default_nettype none

module deep_alpha_substep_counter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire dasc_pkg::in_word_t              in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output dasc_pkg::out_word_t                  out_data,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [dasc_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [dasc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [dasc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                 pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                            state_q;
	dasc_pkg::cfg_t                    cfg;
	dasc_pkg::div_stat_t               div_stat;
	logic [dasc_pkg::SAMPLE_W-1:0]     quotient;
	logic                              div_start;
	logic [dasc_pkg::SAMPLE_W-1:0]     div_dividend;
	logic [dasc_pkg::SAMPLE_W-1:0]     thr;

	// sample held over the iteration
	logic [dasc_pkg::SAMPLE_W-1:0]     alpha_q;
	logic                              pend_q;
	logic                              tstart_q;
	logic [dasc_pkg::SAMPLE_W-1:0]     acc_base_q;
	logic [dasc_pkg::PROD_W-1:0]       prod_q;

	// block state and output register
	logic [dasc_pkg::SAMPLE_W-1:0]     accum_q;
	logic [dasc_pkg::TOTAL_WIDTH-1:0]  total_q;
	logic                              out_valid_q;
	dasc_pkg::out_word_t               out_data_q;

	logic                              in_fire;
	logic                              slot_free;
	logic [dasc_pkg::SAMPLE_W-1:0]     alpha_clamped;
	logic [dasc_pkg::SAMPLE_W-1:0]     acc_clamped;
	logic [dasc_pkg::SAMPLE_W-1:0]     prod_hi;
	logic [dasc_pkg::SAMPLE_W:0]       q_sum;
	logic [dasc_pkg::STEPS_W-1:0]      steps_div;
	logic [dasc_pkg::STEPS_W-1:0]      steps;
	logic [dasc_pkg::TOTAL_WIDTH-1:0]  total_base;
	logic [dasc_pkg::TOTAL_WIDTH:0]    total_sum;
	logic [dasc_pkg::TOTAL_WIDTH-1:0]  total_new;
	logic [dasc_pkg::SAMPLE_W-1:0]     accum_new;
	dasc_pkg::out_word_t               res;

	dasc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dasc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (thr),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// handshakes
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// clamp the incoming alpha and the accumulator to one
	assign alpha_clamped = (in_data.sample_alpha > dasc_pkg::ONE_ALPHA) ? dasc_pkg::ONE_ALPHA
	                                                                    : in_data.sample_alpha;
	assign acc_clamped   = (accum_q > dasc_pkg::ONE_ALPHA) ? dasc_pkg::ONE_ALPHA : accum_q;

	// floor the threshold at the smallest usable limit
	assign thr = (cfg.max_sub_alpha < dasc_pkg::MIN_THRESH) ? dasc_pkg::MIN_THRESH
	                                                        : cfg.max_sub_alpha;

	// round the product up to whole alpha units before dividing by the threshold
	assign prod_hi      = prod_q[dasc_pkg::PROD_W-1:dasc_pkg::ALPHA_FRAC_BITS];
	assign div_dividend = dasc_pkg::SAMPLE_W'(prod_hi
	                    + dasc_pkg::SAMPLE_W'(|prod_q[dasc_pkg::ALPHA_FRAC_BITS-1:0]));
	assign div_start    = (state_q == ST_PREP);

	// ceiling quotient, at least one, saturated to the field
	assign q_sum = {1'b0, quotient} + (dasc_pkg::SAMPLE_W + 1)'(div_stat.rem_nz);
	always_comb begin
		if (q_sum == '0) begin
			steps_div = dasc_pkg::STEPS_W'(1);
		end else if (q_sum > (dasc_pkg::SAMPLE_W + 1)'(dasc_pkg::SUB_MAX)) begin
			steps_div = dasc_pkg::SUB_MAX;
		end else begin
			steps_div = dasc_pkg::STEPS_W'(q_sum);
		end
	end
	assign steps = cfg.alpha_present ? steps_div : dasc_pkg::STEPS_W'(1);

	// saturating tile total
	assign total_base = tstart_q ? '0 : total_q;
	assign total_sum  = {1'b0, total_base} + (dasc_pkg::TOTAL_WIDTH + 1)'(steps);
	assign total_new  = total_sum[dasc_pkg::TOTAL_WIDTH] ? dasc_pkg::TOTAL_MAX
	                                                     : total_sum[dasc_pkg::TOTAL_WIDTH-1:0];

	// over-composite, drop the accumulator at the pixel end
	always_comb begin
		if (pend_q) begin
			accum_new = '0;
		end else if (cfg.alpha_present) begin
			accum_new = dasc_pkg::SAMPLE_W'(acc_base_q + prod_hi);
		end else begin
			accum_new = acc_base_q;
		end
	end

	always_comb begin
		res.sub_steps     = steps;
		res.running_total = dasc_pkg::OUT_TOTAL_W'(total_new);
		res.offset_valid  = pend_q;
	end

	// sequencer, block state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			accum_q     <= '0;
			total_q     <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= res;
						total_q     <= total_new;
						accum_q     <= accum_new;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// capture the word and form the product
	always_ff @(posedge clk) begin
		if (in_fire) begin
			alpha_q    <= alpha_clamped;
			pend_q     <= in_data.pixel_end;
			tstart_q   <= in_data.tile_start;
			acc_base_q <= in_data.tile_start ? '0 : acc_clamped;
		end
		if (state_q == ST_MUL) begin
			prod_q <= alpha_q * (dasc_pkg::ONE_ALPHA - acc_base_q);
		end
	end

	// the divider only finishes while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// an accepted word starts the product in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_MUL) && !in_ready)
		else $error("accepted word did not start");

	// every result has at least one sub-step
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.sub_steps != '0))
		else $error("zero sub-step count");

	// accumulated alpha never exceeds one
	assert property (@(posedge clk) disable iff (!arst_n)
		accum_q <= dasc_pkg::ONE_ALPHA)
		else $error("accumulated alpha above one");

endmodule

`default_nettype wire

### tb/dasc_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dasc_result_checker
// Watches the sample, result and register ports of the deep alpha sub-step
// counter. Keeps its own copy of the registers, the pixel alpha and the tile
// total. Works out the expected result word for every accepted sample and
// checks each accepted result word against the oldest expectation.
// ----------------------------------------------------------------------------

module dasc_result_checker
	import dasc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_word_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_word_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output int                    fail_count,
	output int                    outstanding
);

	// register copies
	logic [SAMPLE_W-1:0]    thr_reg;
	logic                   alpha_on;

	// pixel and tile state
	logic [SAMPLE_W-1:0]    pixel_alpha;
	logic [TOTAL_WIDTH-1:0] tile_total;

	// result words still to come, oldest first
	out_word_t              expected_words[$];
	int                     reported;

	// advance the pixel and tile state by one sample, return its result word
	function automatic out_word_t split_sample(input in_word_t w);
		logic [63:0] a;
		logic [63:0] acc;
		logic [63:0] thr;
		logic [63:0] prod;
		logic [63:0] divisor;
		logic [63:0] quot;
		out_word_t   r;

		a = 64'(w.sample_alpha);
		if (a > 64'(ONE_ALPHA))
			a = 64'(ONE_ALPHA);
		quot = 64'd1;

		// tile start clears everything before this sample
		if (w.tile_start) begin
			tile_total  = '0;
			pixel_alpha = '0;
		end

		if (alpha_on) begin
			acc = 64'(pixel_alpha);
			if (acc > 64'(ONE_ALPHA))
				acc = 64'(ONE_ALPHA);
			thr = 64'(thr_reg);
			if (thr < 64'(MIN_THRESH))
				thr = 64'(MIN_THRESH);
			prod    = a * (64'(ONE_ALPHA) - acc);
			divisor = thr << ALPHA_FRAC_BITS;
			// round the quotient up
			quot = (prod + divisor - 64'd1) / divisor;
			if (quot < 64'd1)
				quot = 64'd1;
			if (quot > 64'(SUB_MAX))
				quot = 64'(SUB_MAX);
			pixel_alpha = SAMPLE_W'(acc + (prod >> ALPHA_FRAC_BITS));
		end

		// saturate the tile total
		if (64'(tile_total) > 64'(TOTAL_MAX) - quot)
			tile_total = TOTAL_MAX;
		else
			tile_total = TOTAL_WIDTH'(64'(tile_total) + quot);

		if (w.pixel_end)
			pixel_alpha = '0;

		r.sub_steps     = STEPS_W'(quot);
		r.running_total = OUT_TOTAL_W'(tile_total);
		r.offset_valid  = w.pixel_end;
		return r;
	endfunction

	// track registers, predict on sample words, compare result words
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		logic      bad;

		if (!arst_n) begin
			thr_reg     = MAX_SUB_ALPHA_RST;
			alpha_on    = 1'b1;
			pixel_alpha = '0;
			tile_total  = '0;
			expected_words.delete();
			fail_count  = 0;
			outstanding <= 0;
			reported    = 0;
		end else begin
			// check result word against the oldest expectation
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					fail_count = fail_count + 1;
					if (reported < 10) begin
						reported = reported + 1;
						$display("%0t: unexpected result: steps %0d total %0d off %0b",
							$realtime, out_data.sub_steps, out_data.running_total,
							out_data.offset_valid);
					end
				end else begin
					want = expected_words.pop_front();
					bad  = 1'b0;
					if (out_data.sub_steps !== want.sub_steps)
						bad = 1'b1;
					if (out_data.running_total !== want.running_total)
						bad = 1'b1;
					if (out_data.offset_valid !== want.offset_valid)
						bad = 1'b1;
					if (bad) begin
						fail_count = fail_count + 1;
						if (reported < 10) begin
							reported = reported + 1;
							$display("%0t: mismatch: exp steps %0d total %0d off %0b,",
								$realtime, want.sub_steps, want.running_total,
								want.offset_valid);
							$display("    got steps %0d total %0d off %0b",
								out_data.sub_steps, out_data.running_total,
								out_data.offset_valid);
						end
					end
				end
			end

			// predict the result of an accepted sample word
			if (in_valid && in_ready)
				expected_words = {expected_words, split_sample(in_data)};

			// follow register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
					REG_MAX_SUB_ALPHA: thr_reg  = pwdata[SAMPLE_W-1:0];
					REG_ALPHA_PRESENT: alpha_on = pwdata[0];
					default: ;
				endcase
			end

			outstanding <= expected_words.size();
		end
	end

endmodule

### tb/deep_alpha_substep_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deep_alpha_substep_counter_tb
// Drives sample words and register writes into the sub-step counter, with
// random gaps on the sample side and random stalls on the result side, and
// gives the verdict from the failure count of the result checker. A directed
// run covers the alpha extremes, the threshold limits and the absent-alpha
// mode; random pixels and tiles follow under several settings.
// ----------------------------------------------------------------------------

module deep_alpha_substep_counter_tb;
	import dasc_pkg::*;

	localparam int HOLD_CYCLES = 400;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_word_t              in_data  = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr    = '0;
	logic [CFG_DATA_W-1:0] pwdata   = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	int                    fail_count;
	int                    outstanding;

	// sample-side gap and result-side stall rates, in percent
	int                    gap_pct   = 0;
	int                    stall_pct = 0;
	logic                  hold_req  = 1'b0;

	// samples left in the pixel being generated
	int                    pix_left  = 0;

	always #6 clk = ~clk;

	deep_alpha_substep_counter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	dasc_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	function automatic in_word_t sample_word(input logic [SAMPLE_W-1:0] alpha,
		input logic pend, input logic tstart);
		in_word_t w;

		w.sample_alpha = alpha;
		w.pixel_end    = pend;
		w.tile_start   = tstart;
		return w;
	endfunction

	// pick an alpha, weighted towards the edges of the range
	function automatic logic [SAMPLE_W-1:0] pick_alpha();
		case ($urandom_range(9))
			0: return '0;
			1: return ONE_ALPHA;
			2: return SAMPLE_W'($urandom_range(65537, 131071));
			3: return SAMPLE_W'($urandom_range(1, 64));
			4: return SAMPLE_W'($urandom_range(65000, 65536));
			default: return SAMPLE_W'($urandom_range(0, 65536));
		endcase
	endfunction

	// mostly whole pixels, now and then a new tile, some noise words
	function automatic in_word_t next_sample();
		logic tstart;

		if ($urandom_range(9) == 0)
			return sample_word(SAMPLE_W'($urandom_range(0, 131071)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
		tstart = 1'b0;
		if (pix_left == 0) begin
			pix_left = $urandom_range(1, 8);
			tstart   = ($urandom_range(7) == 0);
		end
		pix_left = pix_left - 1;
		return sample_word(pick_alpha(), pix_left == 0, tstart);
	endfunction

	// offer one sample word, hold it until taken
	task automatic send_word(input in_word_t w);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < gap_pct);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// stop offering and wait for every expected result word
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// setup then access cycle
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [SAMPLE_W-1:0] thr, input logic present);
		drain_results();
		write_reg(REG_MAX_SUB_ALPHA, CFG_DATA_W'(thr));
		write_reg(REG_ALPHA_PRESENT, CFG_DATA_W'(present));
	endtask

	task automatic run_phase(input logic [SAMPLE_W-1:0] thr, input logic present,
		input int gap, input int stall, input int count);
		set_config(thr, present);
		gap_pct = gap;
		stall_pct <= stall;
		pix_left = 0;
		repeat (count)
			send_word(next_sample());
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		bit hold_done;

		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left = hold_left - 1;
			end else if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				hold_left = HOLD_CYCLES - 1;
				hold_done = 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// stimulus and verdict
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, alpha extremes, pixel and tile flags
		send_word(sample_word(17'h08000, 1'b0, 1'b1));
		send_word(sample_word(17'h00000, 1'b0, 1'b0));
		send_word(sample_word(17'h1FFFF, 1'b1, 1'b0));
		send_word(sample_word(ONE_ALPHA, 1'b1, 1'b1));
		send_word(sample_word(17'h10001, 1'b0, 1'b0));
		send_word(sample_word(17'h00001, 1'b0, 1'b0));
		send_word(sample_word(17'h08000, 1'b1, 1'b0));

		// threshold below the floor
		set_config(17'd0, 1'b1);
		send_word(sample_word(ONE_ALPHA, 1'b0, 1'b1));
		send_word(sample_word(ONE_ALPHA, 1'b1, 1'b0));
		send_word(sample_word(17'h00001, 1'b1, 1'b0));

		// threshold at the floor
		set_config(MIN_THRESH, 1'b1);
		send_word(sample_word(ONE_ALPHA, 1'b1, 1'b0));
		send_word(sample_word(17'h1FFFF, 1'b0, 1'b0));
		send_word(sample_word(17'h04000, 1'b1, 1'b0));

		// threshold of one and above one
		set_config(ONE_ALPHA, 1'b1);
		send_word(sample_word(ONE_ALPHA, 1'b0, 1'b1));
		send_word(sample_word(17'h0FFFF, 1'b1, 1'b0));
		set_config(17'h1FFFF, 1'b1);
		send_word(sample_word(ONE_ALPHA, 1'b0, 1'b0));
		send_word(sample_word(17'h1FFFF, 1'b1, 1'b0));

		// alpha absent: every count one, accumulator frozen
		set_config(17'd100, 1'b0);
		send_word(sample_word(ONE_ALPHA, 1'b0, 1'b1));
		send_word(sample_word(17'h08000, 1'b0, 1'b0));
		send_word(sample_word(17'h00000, 1'b1, 1'b0));
		set_config(17'd100, 1'b1);
		send_word(sample_word(17'h08000, 1'b1, 1'b0));

		// random phases across settings and idling
		run_phase(MAX_SUB_ALPHA_RST, 1'b1, 0, 0, 300);
		run_phase(MIN_THRESH, 1'b1, 69, 0, 250);
		run_phase(ONE_ALPHA, 1'b1, 0, 69, 200);
		run_phase(17'd0, 1'b1, 23, 23, 200);
		run_phase(SAMPLE_W'($urandom_range(7, 65536)), 1'b0, 0, 0, 150);

		// long result hold-off while samples keep coming
		set_config(SAMPLE_W'($urandom_range(7, 500)), 1'b1);
		gap_pct = 0;
		stall_pct <= 0;
		hold_req <= 1'b1;
		repeat (40)
			send_word(next_sample());

		run_phase(17'h1FFFF, 1'b1, 69, 0, 150);
		run_phase(SAMPLE_W'($urandom_range(7, 2000)), 1'b1, 23, 23, 300);

		drain_results();
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// run limit
	initial begin
		#5000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
design/dasc_pkg.sv
design/dasc_apb_regs.sv
design/dasc_div.sv
design/deep_alpha_substep_counter.sv
tb/dasc_result_checker.sv
tb/deep_alpha_substep_counter_tb.sv
